@@ rtl/hmq_pkg.sv @@
package hmq_pkg;

    // Heap geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 11;

    // Packed stream widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = KEY_W;
    localparam int OUT_BITS   = KEY_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Key returned by an extract on an empty heap
    localparam logic [KEY_W-1:0] EMPTY_KEY = KEY_W'(64'd2147483647);

    // Operation codes
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ rtl/hmq_ram.sv @@
module hmq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/binary_min_heap_queue.sv @@
// Binary min-heap priority queue of 64-bit unsigned keys, 1024 entries.
// Input stream: s_axis_tuser selects the operation (0 insert, 1 extract
// minimum), s_axis_tdata carries the key to insert. One transaction in
// gives exactly one transaction out.
// Output stream: m_axis_tdata holds the extracted key (0 on insert, 2147483647
// on an empty heap) and the element count after the operation; m_axis_tuser
// holds the status (0 ok, 1 extract on empty heap, 2 insert dropped, full).
// Processing: an insert reads and compares once per level the new key rises;
// an extract first fetches the root and the last element together, then reads
// and compares once per level the moved key sinks; a dropped insert or an
// empty extract goes straight to the result.
// Each level is one read of the heap memory and one compare and write back, so
// the depth sets the worst case: a key rising all ten levels.
// s_axis_tready rises as the result is registered and the next item is taken
// at the following edge; no item is taken while another is in process. The
// result sits in an output register; while the receiver stalls the next item is
// still processed, and its result waits in place until the output frees up.
// Reset (i_rst_n low, synchronous) empties the heap at once: the element
// count clears and no memory sweep is needed, as slots at or beyond the
// count are never used.
module binary_min_heap_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hmq_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [63:0] key_in
    input  logic                              s_axis_tuser,   // [0] action
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hmq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [63:0] key_out,
                                                              // [74:64] count_after
    output logic [hmq_pkg::STAT_W-1:0]        m_axis_tuser    // [1:0] status
);

    localparam int AW = hmq_pkg::ADDR_W;
    localparam int CW = hmq_pkg::CNT_W;
    localparam int OW = hmq_pkg::COUNT_W;
    localparam int KW = hmq_pkg::KEY_W;
    localparam int SW = hmq_pkg::STAT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_EX_WT  = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [AW-1:0] r_pos,   n_pos;
    logic [KW-1:0] r_key,   n_key;
    logic [KW-1:0] r_res,   n_res;
    logic [SW-1:0] r_stat,  n_stat;

    logic          r_out_valid, n_out_valid;
    logic [KW-1:0] r_out_key,   n_out_key;
    logic [SW-1:0] r_out_stat,  n_out_stat;
    logic [OW-1:0] r_out_cnt,   n_out_cnt;

    // Memory port signals
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [KW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    logic [KW-1:0] mem_rdata_a;
    logic [KW-1:0] mem_rdata_b;

    // Tree navigation
    logic [AW-1:0] parent;
    logic [AW+1:0] lchild;
    logic [AW+1:0] rchild;
    logic          l_valid;
    logic          rc_valid;
    logic          l_lt_key;
    logic          rc_lt_key;
    logic          rc_lt_lc;
    logic          take_r;
    logic          in_xfer;
    logic          out_free;

    hmq_ram #(
        .DEPTH (hmq_pkg::CAPACITY),
        .WIDTH (KW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    // Handshake
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Parent and children of the hole position
    assign parent   = AW'((r_pos - AW'(1)) >> 1);
    assign lchild   = {1'b0, r_pos, 1'b1};
    assign rchild   = lchild + (AW+2)'(1);
    assign l_valid  = lchild < (AW+2)'(r_cnt);
    assign rc_valid = rchild < (AW+2)'(r_cnt);

    // Child compares run in parallel; right wins only if strictly smaller
    assign l_lt_key  = mem_rdata_a < r_key;
    assign rc_lt_key = mem_rdata_b < r_key;
    assign rc_lt_lc  = mem_rdata_b < mem_rdata_a;
    assign take_r    = rc_valid && (l_lt_key ? rc_lt_lc : rc_lt_key);

    // Sequencer and memory control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_key       = r_key;
        n_res       = r_res;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_key   = r_out_key;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_key;
        mem_raddr_a = parent;
        mem_raddr_b = parent;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key = s_axis_tdata;
                    n_res = '0;
                    n_stat = hmq_pkg::ST_OK;
                    if (s_axis_tuser == hmq_pkg::ACT_INSERT) begin
                        if (r_cnt >= CW'(hmq_pkg::CAPACITY)) begin
                            n_stat  = hmq_pkg::ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_pos   = r_cnt[AW-1:0];
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_res   = hmq_pkg::EMPTY_KEY;
                            n_stat  = hmq_pkg::ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            // fetch root and last element together
                            mem_raddr_a = '0;
                            mem_raddr_b = AW'(r_cnt - CW'(1));
                            n_cnt       = r_cnt - CW'(1);
                            n_state     = S_EX_WT;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr_a = parent;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata_a > r_key) begin
                    // parent moves down into the hole
                    mem_wdata = mem_rdata_a;
                    n_pos     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EX_WT: begin
                n_res = mem_rdata_a;
                n_key = mem_rdata_b;
                n_pos = '0;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                mem_raddr_a = lchild[AW-1:0];
                mem_raddr_b = rchild[AW-1:0];
                if (!l_valid) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (take_r) begin
                    mem_wdata = mem_rdata_b;
                    n_pos     = rchild[AW-1:0];
                    n_state   = S_DN_RD;
                end else if (l_lt_key) begin
                    mem_wdata = mem_rdata_a;
                    n_pos     = lchild[AW-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = r_res;
                    n_out_stat  = r_stat;
                    n_out_cnt   = OW'(r_cnt);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_key  <= n_out_key;
        r_out_stat <= n_out_stat;
        r_out_cnt  <= n_out_cnt;
    end

    // Output stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_stat;
    assign m_axis_tdata  = {(hmq_pkg::OUT_DATA_W - hmq_pkg::OUT_BITS)'(0),
                            r_out_cnt, r_out_key};

endmodule

@@ rtl/hmq_checker.sv @@
module hmq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [hmq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [hmq_pkg::STAT_W-1:0]        m_axis_tuser
);

    localparam int KW = hmq_pkg::KEY_W;
    localparam int CW = hmq_pkg::COUNT_W;

    logic [KW-1:0] key_out;
    logic [CW-1:0] cnt_out;

    assign key_out = m_axis_tdata[KW-1:0];
    assign cnt_out = m_axis_tdata[KW+CW-1:KW];

    // A stalled result holds its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // The count never exceeds the heap capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cnt_out <= CW'(hmq_pkg::CAPACITY))
        else $error("count beyond capacity");

    // Empty extract returns the sentinel with a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == hmq_pkg::ST_EMPTY |->
            key_out == hmq_pkg::EMPTY_KEY && cnt_out == '0)
        else $error("bad empty-heap result");

    // Dropped insert reports a full heap and a zero key
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == hmq_pkg::ST_FULL |->
            key_out == '0 && cnt_out == CW'(hmq_pkg::CAPACITY))
        else $error("bad full-heap result");

    // Only defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == hmq_pkg::ST_OK ||
            m_axis_tuser == hmq_pkg::ST_EMPTY || m_axis_tuser == hmq_pkg::ST_FULL)
        else $error("undefined status code");

endmodule

bind binary_min_heap_queue hmq_checker u_hmq_checker (.*);

@@ sim/tb_binary_min_heap_queue.sv @@
module tb_binary_min_heap_queue;

    localparam int KW  = hmq_pkg::KEY_W;
    localparam int SW  = hmq_pkg::STAT_W;
    localparam int NW  = hmq_pkg::COUNT_W;
    localparam int CAP = hmq_pkg::CAPACITY;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int MIXED_ITEMS    = 40;
    localparam int DIR_ROWS       = 24;
    localparam int EXP_DEPTH      = 16;
    localparam logic [KW-1:0] KEY_ONES = '1;
    localparam logic [KW-1:0] KEY_MSB  = {1'b1, {(KW-1){1'b0}}};

    typedef struct packed {
        logic [KW-1:0] key;
        logic [SW-1:0] status;
        logic [NW-1:0] count;
    } t_heap_result;

    typedef struct packed {
        logic          act;
        logic [KW-1:0] key;
        logic          typed;
        t_heap_result  want;
    } t_stim_row;

    // DUT ports
    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [hmq_pkg::IN_DATA_W-1:0]       s_axis_tdata = '0;   // [63:0] key_in
    logic                                s_axis_tuser = 1'b0;  // [0] action
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [hmq_pkg::OUT_DATA_W-1:0]      m_axis_tdata;  // [63:0] key_out, [74:64] count_after
    logic [SW-1:0]                       m_axis_tuser;  // [1:0] status

    // Heap mirror, expected results ring and directed table
    logic [KW-1:0] heap_mirror [CAP];
    int            heap_size = 0;
    t_heap_result  exp_ring [EXP_DEPTH];
    int            exp_wr = 0;
    int            exp_rd = 0;
    t_stim_row     dir_rows [DIR_ROWS];
    int            dir_cnt = 0;

    int error_count = 0;
    int quiet_cycles = 0;
    bit stall_en = 1'b1;

    binary_min_heap_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the heap mirror and return the result it gives
    function automatic t_heap_result heap_apply(logic act, logic [KW-1:0] key);
        t_heap_result  res;
        int            pos;
        int            up;
        int            lc;
        int            rc;
        int            best;
        logic [KW-1:0] tmp;
        res = '0;
        res.status = hmq_pkg::ST_OK;
        if (act == hmq_pkg::ACT_INSERT) begin
            if (heap_size >= CAP) begin
                res.status = hmq_pkg::ST_FULL;
            end else begin
                pos = heap_size;
                heap_mirror[pos] = key;
                heap_size++;
                // sift up while the parent is strictly larger
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (heap_mirror[up] <= heap_mirror[pos]) break;
                    tmp = heap_mirror[up];
                    heap_mirror[up] = heap_mirror[pos];
                    heap_mirror[pos] = tmp;
                    pos = up;
                end
            end
        end else if (heap_size == 0) begin
            res.key = hmq_pkg::EMPTY_KEY;
            res.status = hmq_pkg::ST_EMPTY;
        end else begin
            res.key = heap_mirror[0];
            heap_size--;
            if (heap_size > 0) begin
                heap_mirror[0] = heap_mirror[heap_size];
                pos = 0;
                // sift down toward the smaller child, left wins a tie
                while (1) begin
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    best = pos;
                    if (lc < heap_size && heap_mirror[lc] < heap_mirror[pos]) best = lc;
                    if (rc < heap_size && heap_mirror[rc] < heap_mirror[best]) best = rc;
                    if (best == pos) break;
                    tmp = heap_mirror[pos];
                    heap_mirror[pos] = heap_mirror[best];
                    heap_mirror[best] = tmp;
                    pos = best;
                end
            end
        end
        res.count = NW'(heap_size);
        return res;
    endfunction

    // Append one row to the directed table
    task automatic add_row(logic act, logic [KW-1:0] key, logic typed,
                           logic [KW-1:0] k, logic [SW-1:0] s, int c);
        t_stim_row r;
        r.act = act;
        r.key = key;
        r.typed = typed;
        r.want.key = k;
        r.want.status = s;
        r.want.count = NW'(c);
        dir_rows[dir_cnt] = r;
        dir_cnt++;
    endtask

    // Key mix: full range, small values for duplicates, near-max, single bits, 32-bit values
    function automatic logic [KW-1:0] rand_key();
        case ($urandom_range(9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4, 5, 6:    return KW'($urandom_range(15));
            7:          return KEY_ONES - KW'($urandom_range(3));
            8:          return KW'(1) << $urandom_range(KW - 1);
            default:    return {32'h0, $urandom};
        endcase
    endfunction

    function automatic logic rand_act();
        return ($urandom_range(99) < 45) ? hmq_pkg::ACT_EXTRACT : hmq_pkg::ACT_INSERT;
    endfunction

    // Offer one transaction; on acceptance record what it must produce
    task automatic push_op(logic act, logic [KW-1:0] key, logic typed, t_heap_result want);
        t_heap_result res;
        while (stall_en && $urandom_range(99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        res = heap_apply(act, key);
        exp_ring[exp_wr % EXP_DEPTH] = typed ? want : res;
        exp_wr++;
    endtask

    task automatic note_mismatch(string what, t_heap_result want, t_heap_result got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $write("mismatch (%s): want key=%h status=%0d count=%0d",
                   what, want.key, want.status, want.count);
            $display(", got key=%h status=%0d count=%0d", got.key, got.status, got.count);
        end
    endtask

    // Result side: check each transaction, then pick the next ready level
    always @(posedge i_clk) begin : check_results
        t_heap_result got;
        t_heap_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.key    = m_axis_tdata[KW-1:0];
            got.count  = m_axis_tdata[KW +: NW];
            got.status = m_axis_tuser;
            if (exp_wr == exp_rd) begin
                note_mismatch("no result pending", '0, got);
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.key !== want.key || got.status !== want.status ||
                    got.count !== want.count)
                    note_mismatch("result", want, got);
            end
        end
        m_axis_tready <= stall_en ? ($urandom_range(99) >= 19) : 1'b1;
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n;
        // directed rows: empty, extremes, duplicates, ordering, ignored key on extract
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0, 1'b1, hmq_pkg::EMPTY_KEY, hmq_pkg::ST_EMPTY, 0);
        add_row(hmq_pkg::ACT_INSERT,  KEY_ONES, 1'b1, 64'd0,     hmq_pkg::ST_OK, 1);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, KEY_ONES,  hmq_pkg::ST_OK, 0);
        add_row(hmq_pkg::ACT_INSERT,  64'd0,    1'b1, 64'd0,     hmq_pkg::ST_OK, 1);
        add_row(hmq_pkg::ACT_INSERT,  KEY_ONES, 1'b1, 64'd0,     hmq_pkg::ST_OK, 2);
        add_row(hmq_pkg::ACT_INSERT,  64'd5,    1'b1, 64'd0,     hmq_pkg::ST_OK, 3);
        add_row(hmq_pkg::ACT_INSERT,  64'd5,    1'b1, 64'd0,     hmq_pkg::ST_OK, 4);
        add_row(hmq_pkg::ACT_INSERT,  64'd3,    1'b1, 64'd0,     hmq_pkg::ST_OK, 5);
        add_row(hmq_pkg::ACT_INSERT,  KEY_MSB,  1'b1, 64'd0,     hmq_pkg::ST_OK, 6);
        add_row(hmq_pkg::ACT_INSERT,  ~KEY_MSB, 1'b1, 64'd0,     hmq_pkg::ST_OK, 7);
        add_row(hmq_pkg::ACT_INSERT,  64'd1,    1'b1, 64'd0,     hmq_pkg::ST_OK, 8);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, 64'd0,     hmq_pkg::ST_OK, 7);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, 64'd1,     hmq_pkg::ST_OK, 6);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, 64'd3,     hmq_pkg::ST_OK, 5);
        add_row(hmq_pkg::ACT_EXTRACT, KEY_ONES, 1'b1, 64'd5,     hmq_pkg::ST_OK, 4);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, 64'd5,     hmq_pkg::ST_OK, 3);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, ~KEY_MSB,  hmq_pkg::ST_OK, 2);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, KEY_MSB,   hmq_pkg::ST_OK, 1);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0,    1'b1, KEY_ONES,  hmq_pkg::ST_OK, 0);
        add_row(hmq_pkg::ACT_INSERT, hmq_pkg::EMPTY_KEY, 1'b1, 64'd0, hmq_pkg::ST_OK, 1);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd0, 1'b1, hmq_pkg::EMPTY_KEY, hmq_pkg::ST_OK, 0);
        add_row(hmq_pkg::ACT_INSERT,  64'd9,    1'b0, 64'd0,     hmq_pkg::ST_OK, 0);
        add_row(hmq_pkg::ACT_INSERT,  64'd2,    1'b0, 64'd0,     hmq_pkg::ST_OK, 0);
        add_row(hmq_pkg::ACT_EXTRACT, 64'd7,    1'b0, 64'd0,     hmq_pkg::ST_OK, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_cnt; i++)
            push_op(dir_rows[i].act, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

        // short mixed traffic
        for (int i = 0; i < MIXED_ITEMS; i++)
            push_op(rand_act(), rand_key(), 1'b0, '0);

        // fill to capacity, with a stretch where neither side idles
        n = 0;
        while (heap_size < CAP) begin
            stall_en = !(n >= 300 && n < 500);
            push_op(hmq_pkg::ACT_INSERT, rand_key(), 1'b0, '0);
            n++;
        end
        stall_en = 1'b1;

        // inserts that must be dropped
        repeat (8) push_op(hmq_pkg::ACT_INSERT, rand_key(), 1'b0, '0);

        // churn around the full boundary
        repeat (30) push_op(($urandom_range(1) == 0) ? hmq_pkg::ACT_EXTRACT : hmq_pkg::ACT_INSERT,
                            rand_key(), 1'b0, '0);

        // deep sift-down on a large heap
        repeat (40) push_op(($urandom_range(99) < 90) ? hmq_pkg::ACT_EXTRACT :
                            hmq_pkg::ACT_INSERT, rand_key(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hmq_pkg.sv
rtl/hmq_ram.sv
rtl/binary_min_heap_queue.sv
rtl/hmq_checker.sv
sim/tb_binary_min_heap_queue.sv
